### design/isrt_pkg.sv
// ----------------------------------------------------------------------------
// isrt_pkg
// Shared types and constants for the streaming insertion sorter.
// ----------------------------------------------------------------------------
package isrt_pkg;

   localparam int DATA_W = 32;

   typedef logic signed [DATA_W-1:0] data_type;

   // Contents of one cell of the sorting chain
   typedef struct packed {
      logic     valid;
      data_type value;
   } cell_data_type;

   // Per-cycle command broadcast to every cell
   typedef struct packed {
      logic ins;    // insert the broadcast value
      logic shift;  // move every entry one cell toward the head
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_FILL  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

endpackage

### design/isrt_intf.sv
// ----------------------------------------------------------------------------
// isrt_intf
// Valid/ready channels for sorter input values and sorted results.
// ----------------------------------------------------------------------------
interface isrt_req_intf;
   logic                valid;
   logic                ready;
   logic signed [31:0]  value;
   logic                last_in;

   modport source (output valid, output value, output last_in, input ready);
   modport sink   (input valid, input value, input last_in, output ready);
endinterface

interface isrt_rsp_intf;
   logic                valid;
   logic                ready;
   logic signed [31:0]  sorted_value;
   logic                last_out;
   logic                overflow;

   modport source (output valid, output sorted_value, output last_out, output overflow,
                   input ready);
   modport sink   (input valid, input sorted_value, input last_out, input overflow,
                   output ready);
endinterface

### design/isrt_cell.sv
// ----------------------------------------------------------------------------
// isrt_cell
// One slot of the systolic insertion chain: keeps its entry, takes the
// broadcast value, or takes its neighbor's entry.
// ----------------------------------------------------------------------------
module isrt_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  isrt_pkg::cell_ctrl_type ctrl,
   input  isrt_pkg::data_type      new_value,
   input  isrt_pkg::cell_data_type left_data,
   input  logic                   left_le,
   input  isrt_pkg::cell_data_type right_data,
   output isrt_pkg::cell_data_type data,
   output logic                   le
);
   import isrt_pkg::*;

   logic     valid_ff, valid_in;
   data_type value_ff, value_in;
   logic     gt;

   // Empty cells rank above every value, so the store stays contiguous
   assign gt   = !valid_ff || (value_ff > new_value);
   assign le   = !gt;
   assign data = '{valid: valid_ff, value: value_ff};

   // Choose next contents: keep, take new value, or take a neighbor
   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (ctrl.ins && gt) begin
         if (left_le) begin
            valid_in = 1'b1;
            value_in = new_value;
         end else begin
            valid_in = left_data.valid;
            value_in = left_data.value;
         end
      end else if (ctrl.shift) begin
         valid_in = right_data.valid;
         value_in = right_data.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

### design/insertion_sorter_core.sv
// ----------------------------------------------------------------------------
// insertion_sorter_core
// Stable streaming sort of one batch of signed 32-bit values.
// ----------------------------------------------------------------------------
// Usage: send a batch on req_ch, one value per transaction, with last_in set
// on the final one. During fill req_ch.ready is high and one value is taken
// every cycle; each value is compared in parallel by a chain of CAPACITY
// cells and slots in behind all equal or smaller entries in that same cycle.
// Values that arrive while all CAPACITY cells are occupied are discarded and
// the batch is flagged as overflowed.
// After the last transaction the block drains: the head cell of the chain
// drives rsp_ch, so the first result is offered the cycle after last_in is
// taken, and the chain moves one step toward the head per accepted result,
// giving one result per cycle while rsp_ch.ready stays high. A stalled
// receiver simply holds the chain. req_ch.ready is low for the whole drain,
// so values of a new batch are taken only after the previous one has drained.
// last_out marks the final result; overflow repeats on every result of an
// overflowed batch. Reset empties the chain and clears the overflow flag.
// ----------------------------------------------------------------------------
module insertion_sorter_core #(
   parameter int CAPACITY = 64
) (
   input  logic         clock,
   input  logic         reset,
   isrt_req_intf.sink   req_ch,
   isrt_rsp_intf.source rsp_ch
);
   import isrt_pkg::*;

   state_type     state_ff, state_in;
   logic          dropped_ff, dropped_in;
   cell_ctrl_type ctrl;
   cell_data_type chain [CAPACITY];
   logic          le_vec [CAPACITY];
   logic          req_fire, rsp_fire, full;

   assign full     = chain[CAPACITY-1].valid;
   assign req_fire = req_ch.valid && req_ch.ready;
   assign rsp_fire = rsp_ch.valid && rsp_ch.ready;

   // Handshakes from the state; result fields from the head cells and drop flag
   assign req_ch.ready        = (state_ff == ST_FILL);
   assign rsp_ch.valid        = (state_ff == ST_DRAIN);
   assign rsp_ch.sorted_value = chain[0].value;
   assign rsp_ch.last_out     = !chain[1].valid;
   assign rsp_ch.overflow     = dropped_ff;

   assign ctrl.ins   = req_fire && !full;
   assign ctrl.shift = rsp_fire;

   // Build the chain
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      cell_data_type left_d, right_d;
      logic          left_le;
      if (i == 0) begin : g_head
         assign left_d  = '{valid: 1'b0, value: req_ch.value};
         assign left_le = 1'b1;
      end else begin : g_body
         assign left_d  = chain[i-1];
         assign left_le = le_vec[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign right_d = '{valid: 1'b0, value: chain[i].value};
      end else begin : g_mid
         assign right_d = chain[i+1];
      end
      isrt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .new_value  (req_ch.value),
         .left_data  (left_d),
         .left_le    (left_le),
         .right_data (right_d),
         .data       (chain[i]),
         .le         (le_vec[i])
      );
   end

   // Sequence fill and drain, track drops
   always_comb begin
      state_in   = state_ff;
      dropped_in = dropped_ff;
      unique case (state_ff)
         ST_FILL: begin
            if (req_fire && full) begin
               dropped_in = 1'b1;
            end
            if (req_fire && req_ch.last_in) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (rsp_fire && rsp_ch.last_out) begin
               state_in   = ST_FILL;
               dropped_in = 1'b0;
            end
         end
         default: begin
            state_in   = ST_FILL;
            dropped_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_FILL;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         dropped_ff <= dropped_in;
      end
   end

`ifndef SYNTH
   // Draining always has a head entry to present
   a_drain_head: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN |-> chain[0].valid)
      else $error("drain with empty head cell");

   // Any accepted value leaves the head cell occupied
   a_head_after_req: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> chain[0].valid)
      else $error("head cell empty after accepted value");

   // Final result empties the chain
   a_empty_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_ch.last_out |=> !chain[0].valid && !dropped_ff)
      else $error("chain not empty after final result");
`endif

endmodule
